// ----- hdl/wos_pkg.sv -----
`default_nettype none

package wos_pkg;

  localparam int unsigned MaxSamplesDef = 64;
  localparam int unsigned SampleBitsDef = 24;

  localparam int unsigned MinCountW   = 7;
  localparam int unsigned FloorW      = 23;
  localparam int unsigned CountW      = 7;
  localparam int unsigned CfgIndexW   = 8;
  localparam int unsigned CfgDataW    = 23;
  localparam int unsigned PctDivisor  = 20;
  localparam int unsigned PctHighMul  = 19;
  localparam int unsigned PctRecipMul = 52429;
  localparam int unsigned PctRecipW   = 16;
  localparam int unsigned PctRecipShift = 20;
  localparam int unsigned MinCountRst = 3;
  localparam int unsigned FloorRst    = 3277;
  localparam int unsigned MinCountLow = 2;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MIN_COUNT    = 8'd0,
    REG_STDDEV_FLOOR = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    RD_INS,
    RD_MED_LO,
    RD_MED_HI,
    RD_VAR,
    RD_PCT_LO,
    RD_PCT_HI
  } rd_sel_e;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_FIN,
    ST_MED_RD,
    ST_MED_A,
    ST_MED_B,
    ST_MEAN,
    ST_VAR_RD,
    ST_VAR_SQ,
    ST_VAR_ACC,
    ST_VAR_DIV,
    ST_SQRT,
    ST_PCT_LO_RD,
    ST_PCT_LO,
    ST_PCT_HI,
    ST_PUBLISH
  } state_e;

  typedef struct packed {
    logic     cap;
    logic     ovf_set;
    logic     pos_load_cnt;
    logic     pos_dec;
    logic     pos_clr;
    logic     pos_inc;
    logic     ins_wr_x;
    logic     ins_wr_shift;
    rd_sel_e  rd_sel;
    logic     med_a_ld;
    logic     med_odd_ld;
    logic     med_even_ld;
    logic     div_start;
    div_sel_e div_sel;
    logic     mean_ld;
    logic     sq_ld;
    logic     acc_clr;
    logic     acc_ld;
    logic     sqrt_start;
    logic     sd_ld;
    logic     ilo_ld;
    logic     ihi_ld;
    logic     lo_ld;
    logic     hi_ld;
    logic     publish;
  } wos_cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic gt;
    logic stats_ok;
    logic n_odd;
    logic var_last;
    logic div_done;
    logic sqrt_done;
  } wos_status_t;

endpackage

`default_nettype wire

// ----- hdl/wos_divider.sv -----
`default_nettype none

module wos_divider import wos_pkg::*; #(
  parameter int unsigned Width = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic [Width-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width:0]   rem_q, rem_d;
  logic [Width-1:0] quot_q, quot_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;

  always_comb begin
    shifted = {rem_q[Width-1:0], quot_q[Width-1]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quot_d  = quot_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d  = diff;
        quot_d = {quot_q[Width-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

// ----- hdl/wos_sqrt.sv -----
`default_nettype none

module wos_sqrt import wos_pkg::*; #(
  parameter int unsigned Width = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [Width-1:0]       value_i,
  output logic                        done_o,
  output logic [(Width+1)/2-1:0]      root_o
);

  localparam int unsigned HalfW = (Width + 1) / 2;
  localparam int unsigned PadW  = 2 * HalfW;
  localparam int unsigned RemW  = HalfW + 2;
  localparam int unsigned CntW  = $clog2(HalfW + 1);

  logic [PadW-1:0]  val_q, val_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [HalfW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW+1:0]  shifted;
  logic [RemW+1:0]  trial;

  always_comb begin
    shifted = {rem_q, val_q[PadW-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    val_d   = val_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      val_d  = PadW'(value_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(HalfW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[PadW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = RemW'(shifted - trial);
        root_d = {root_q[HalfW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(shifted);
        root_d = {root_q[HalfW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- hdl/wos_datapath.sv -----
`default_nettype none

module wos_datapath import wos_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [CfgIndexW-1:0]         cfg_index_i,
  input  wire logic [CfgDataW-1:0]          cfg_data_i,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire wos_cmd_t                     cmd_i,
  output wos_status_t                       status_o,
  output logic                              stats_valid_o,
  output logic [CountW-1:0]                 kept_count_o,
  output logic signed [SampleBits-1:0]      median_value_o,
  output logic signed [SampleBits-1:0]      mean_value_o,
  output logic [FloorW-1:0]                 std_deviation_o,
  output logic signed [SampleBits-1:0]      low_percentile_o,
  output logic signed [SampleBits-1:0]      high_percentile_o,
  output logic                              overflowed_o
);

  localparam int unsigned IdxW  = $clog2(MaxSamples);
  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned SumW  = SampleBits + CntW;
  localparam int unsigned SqW   = 2 * SampleBits;
  localparam int unsigned AccW  = 2 * SampleBits + CntW;
  localparam int unsigned HalfW = (AccW + 1) / 2;
  localparam int unsigned CmpW  = (HalfW > FloorW) ? HalfW : FloorW;
  localparam int unsigned NCmpW = (CntW > MinCountW) ? CntW : MinCountW;
  localparam int unsigned PctW  = CntW + 5;
  localparam int unsigned ProdW = PctW + PctRecipW;
  localparam logic [CmpW-1:0] StdMax = CmpW'((64'd1 << (SampleBits - 1)) - 64'd1);

  logic signed [SampleBits-1:0] mem [MaxSamples];
  logic signed [SampleBits-1:0] rdata_q;
  logic [IdxW-1:0]              raddr;
  logic [IdxW-1:0]              waddr;
  logic signed [SampleBits-1:0] wdata;
  logic                         wr_en;

  logic [MinCountW-1:0]         min_count_q;
  logic [FloorW-1:0]            floor_q;
  logic signed [SampleBits-1:0] x_q;
  logic [CntW-1:0]              cnt_q;
  logic signed [SumW-1:0]       sum_q;
  logic                         ovf_q;
  logic [CntW-1:0]              pos_q;
  logic signed [SampleBits-1:0] med_a_q, median_q, mean_q, lo_q, hi_q;
  logic [SqW-1:0]               sq_q;
  logic [AccW-1:0]              acc_q;
  logic [FloorW-1:0]            sd_q;
  logic [CntW-1:0]              ilo_q, ihi_q;

  logic [CntW-1:0]              half_n;
  logic [NCmpW-1:0]             need;
  logic [SumW-1:0]              sum_abs;
  logic signed [SampleBits:0]   dev;
  logic signed [2*SampleBits+1:0] dev_sq;
  logic signed [SampleBits:0]   med_sum;
  logic [PctW-1:0]              n19;
  logic [ProdW-1:0]             ilo_prod, ihi_prod;
  logic [AccW-1:0]              div_a, div_b, quot;
  logic                         div_done, sqrt_done;
  logic [HalfW-1:0]             root;
  logic [CmpW-1:0]              sd_sat, sd_fin;
  logic signed [SampleBits-1:0] mean_next;

  assign half_n = cnt_q >> 1;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_INS:    raddr = IdxW'(pos_q - 1'b1);
      RD_MED_LO: raddr = cnt_q[0] ? IdxW'(half_n) : IdxW'(half_n - 1'b1);
      RD_MED_HI: raddr = IdxW'(half_n);
      RD_VAR:    raddr = pos_q[IdxW-1:0];
      RD_PCT_LO: raddr = ilo_q[IdxW-1:0];
      RD_PCT_HI: raddr = ihi_q[IdxW-1:0];
      default:   raddr = '0;
    endcase
  end

  assign wr_en = cmd_i.ins_wr_x | cmd_i.ins_wr_shift;
  assign waddr = pos_q[IdxW-1:0];
  assign wdata = cmd_i.ins_wr_x ? x_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign n19     = PctW'(cnt_q) * PctW'(PctHighMul);

  // Division by twenty is done as a multiplication by a scaled reciprocal.
  assign ilo_prod = ProdW'(cnt_q) * ProdW'(PctRecipMul);
  assign ihi_prod = ProdW'(n19) * ProdW'(PctRecipMul);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_a = AccW'(sum_abs);
        div_b = AccW'(cnt_q);
      end
      DIV_VAR: begin
        div_a = acc_q;
        div_b = AccW'(cnt_q - 1'b1);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  wos_divider #(
    .Width (AccW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  wos_sqrt #(
    .Width (AccW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign mean_next = sum_q[SumW-1] ? -$signed(quot[SampleBits-1:0])
                                   : $signed(quot[SampleBits-1:0]);
  assign dev     = $signed({rdata_q[SampleBits-1], rdata_q})
                 - $signed({mean_q[SampleBits-1], mean_q});
  assign dev_sq  = dev * dev;
  assign med_sum = $signed({med_a_q[SampleBits-1], med_a_q})
                 + $signed({rdata_q[SampleBits-1], rdata_q});
  assign sd_sat  = (CmpW'(root) > StdMax) ? StdMax : CmpW'(root);
  assign sd_fin  = (sd_sat < CmpW'(floor_q)) ? CmpW'(floor_q) : sd_sat;
  assign need    = (min_count_q < MinCountW'(MinCountLow)) ? NCmpW'(MinCountLow)
                                                           : NCmpW'(min_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= MinCountW'(MinCountRst);
      floor_q     <= FloorW'(FloorRst);
      cnt_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MIN_COUNT:    min_count_q <= cfg_data_i[MinCountW-1:0];
          REG_STDDEV_FLOOR: floor_q     <= cfg_data_i[FloorW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.ovf_set) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.ins_wr_x) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + SumW'(x_q);
      end
      if (cmd_i.pos_load_cnt) begin
        pos_q <= cnt_q;
      end else if (cmd_i.pos_dec) begin
        pos_q <= pos_q - 1'b1;
      end else if (cmd_i.pos_clr) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.publish) begin
        cnt_q <= '0;
        sum_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      x_q <= sample_i;
    end
    if (cmd_i.med_a_ld) begin
      med_a_q <= rdata_q;
    end
    if (cmd_i.med_odd_ld) begin
      median_q <= rdata_q;
    end
    if (cmd_i.med_even_ld) begin
      median_q <= med_sum[SampleBits:1];
    end
    if (cmd_i.mean_ld) begin
      mean_q <= mean_next;
    end
    if (cmd_i.sq_ld) begin
      sq_q <= dev_sq[SqW-1:0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_ld) begin
      acc_q <= acc_q + AccW'(sq_q);
    end
    if (cmd_i.sd_ld) begin
      sd_q <= sd_fin[FloorW-1:0];
    end
    if (cmd_i.ilo_ld) begin
      ilo_q <= ilo_prod[PctRecipShift +: CntW];
    end
    if (cmd_i.ihi_ld) begin
      ihi_q <= ihi_prod[PctRecipShift +: CntW];
    end
    if (cmd_i.lo_ld) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.hi_ld) begin
      hi_q <= rdata_q;
    end
    if (cmd_i.publish) begin
      stats_valid_o     <= status_o.stats_ok;
      kept_count_o      <= CountW'(cnt_q);
      overflowed_o      <= ovf_q;
      median_value_o    <= status_o.stats_ok ? median_q : '0;
      mean_value_o      <= status_o.stats_ok ? mean_q : '0;
      std_deviation_o   <= status_o.stats_ok ? sd_q : '0;
      low_percentile_o  <= status_o.stats_ok ? lo_q : '0;
      high_percentile_o <= status_o.stats_ok ? hi_q : '0;
    end
  end

  always_comb begin
    status_o.full      = (cnt_q == CntW'(MaxSamples));
    status_o.pos_zero  = (pos_q == '0);
    status_o.gt        = (rdata_q > x_q);
    status_o.stats_ok  = (NCmpW'(cnt_q) >= need);
    status_o.n_odd     = cnt_q[0];
    status_o.var_last  = ((pos_q + 1'b1) == cnt_q);
    status_o.div_done  = div_done;
    status_o.sqrt_done = sqrt_done;
  end

endmodule

`default_nettype wire

// ----- hdl/wos_ctrl.sv -----
`default_nettype none

module wos_ctrl import wos_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        missing_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire wos_status_t status_i,
  output wos_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap = 1'b1;
          last_d    = last_i;
          if (!missing_i && !status_i.full) begin
            cmd_o.pos_load_cnt = 1'b1;
            state_d            = ST_INS_RD;
          end else begin
            cmd_o.ovf_set = !missing_i;
            state_d       = last_i ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_INS_RD: begin
        cmd_o.rd_sel = RD_INS;
        if (status_i.pos_zero) begin
          cmd_o.ins_wr_x = 1'b1;
          state_d        = last_q ? ST_FIN : ST_IDLE;
        end else begin
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (status_i.gt) begin
          cmd_o.ins_wr_shift = 1'b1;
          cmd_o.pos_dec      = 1'b1;
          state_d            = ST_INS_RD;
        end else begin
          cmd_o.ins_wr_x = 1'b1;
          state_d        = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        state_d = status_i.stats_ok ? ST_MED_RD : ST_PUBLISH;
      end
      ST_MED_RD: begin
        cmd_o.rd_sel = RD_MED_LO;
        state_d      = ST_MED_A;
      end
      ST_MED_A: begin
        if (status_i.n_odd) begin
          cmd_o.med_odd_ld = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.div_sel    = DIV_MEAN;
          state_d          = ST_MEAN;
        end else begin
          cmd_o.med_a_ld = 1'b1;
          cmd_o.rd_sel   = RD_MED_HI;
          state_d        = ST_MED_B;
        end
      end
      ST_MED_B: begin
        cmd_o.med_even_ld = 1'b1;
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel     = DIV_MEAN;
        state_d           = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.div_sel = DIV_MEAN;
        if (status_i.div_done) begin
          cmd_o.mean_ld = 1'b1;
          cmd_o.pos_clr = 1'b1;
          cmd_o.acc_clr = 1'b1;
          state_d       = ST_VAR_RD;
        end
      end
      ST_VAR_RD: begin
        cmd_o.rd_sel = RD_VAR;
        state_d      = ST_VAR_SQ;
      end
      ST_VAR_SQ: begin
        cmd_o.sq_ld = 1'b1;
        state_d     = ST_VAR_ACC;
      end
      ST_VAR_ACC: begin
        cmd_o.acc_ld  = 1'b1;
        cmd_o.pos_inc = 1'b1;
        state_d       = status_i.var_last ? ST_VAR_DIV : ST_VAR_RD;
      end
      ST_VAR_DIV: begin
        cmd_o.div_sel   = DIV_VAR;
        cmd_o.div_start = !status_i.div_done && !last_q;
        last_d          = 1'b1;
        if (status_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (status_i.sqrt_done) begin
          cmd_o.sd_ld  = 1'b1;
          cmd_o.ilo_ld = 1'b1;
          cmd_o.ihi_ld = 1'b1;
          state_d      = ST_PCT_LO_RD;
        end
      end
      ST_PCT_LO_RD: begin
        cmd_o.rd_sel = RD_PCT_LO;
        state_d      = ST_PCT_LO;
      end
      ST_PCT_LO: begin
        cmd_o.lo_ld  = 1'b1;
        cmd_o.rd_sel = RD_PCT_HI;
        state_d      = ST_PCT_HI;
      end
      ST_PCT_HI: begin
        cmd_o.hi_ld = 1'b1;
        state_d     = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_VAR_ACC && status_i.var_last) begin
      last_d = 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over a beat that was not taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !status_i.div_done)
    else $error("divider finished right after a start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins_wr_x |-> !status_i.full)
    else $error("sample stored into a full window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !missing_i && status_i.full) |-> cmd_o.ovf_set)
    else $error("dropped sample did not flag overflow");

endmodule

`default_nettype wire

// ----- hdl/window_order_statistics_core.sv -----
// An item is taken while the core is idle; a kept sample then walks down the sorted store,
// one read and one compare for each of the k entries it moves past, then it is stored.
// After the last beat, with enough samples kept, median, mean, variance, root, percentiles
// follow, then publish; divider and root use AccW = 2*SampleBits+clog2(MaxSamples+1) bits.
// Throughput: one item at a time; input waits while an item or a window finish runs.
// Reset clears counters, overflow flag and control state and sets registers to defaults.
`default_nettype none

module window_order_statistics_core import wos_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CfgIndexW-1:0]         cfg_index_i,
  input  wire logic [CfgDataW-1:0]          cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire logic                         missing_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              stats_valid_o,
  output logic [CountW-1:0]                 kept_count_o,
  output logic signed [SampleBits-1:0]      median_value_o,
  output logic signed [SampleBits-1:0]      mean_value_o,
  output logic [FloorW-1:0]                 std_deviation_o,
  output logic signed [SampleBits-1:0]      low_percentile_o,
  output logic signed [SampleBits-1:0]      high_percentile_o,
  output logic                              overflowed_o
);

  wos_cmd_t    cmd;
  wos_status_t status;

  assign cfg_ready_o = 1'b1;

  wos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .missing_i   (missing_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wos_datapath #(
    .MaxSamples (MaxSamples),
    .SampleBits (SampleBits)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .sample_i          (sample_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .stats_valid_o     (stats_valid_o),
    .kept_count_o      (kept_count_o),
    .median_value_o    (median_value_o),
    .mean_value_o      (mean_value_o),
    .std_deviation_o   (std_deviation_o),
    .low_percentile_o  (low_percentile_o),
    .high_percentile_o (high_percentile_o),
    .overflowed_o      (overflowed_o)
  );

endmodule

`default_nettype wire

// ----- verif/window_order_statistics_core_test.sv -----
`default_nettype none

module window_order_statistics_core_test;
  import wos_pkg::*;

  localparam int unsigned Capacity = MaxSamplesDef;
  localparam int unsigned SampleW = SampleBitsDef;
  localparam logic [CfgIndexW-1:0] UnusedIndexA = 8'd2;
  localparam logic [CfgIndexW-1:0] UnusedIndexB = 8'hff;
  localparam int unsigned SettleCycles = 400;

  typedef struct packed {
    bit                        stats_valid;
    bit [CountW-1:0]           kept_count;
    bit signed [SampleW-1:0]   median_value;
    bit signed [SampleW-1:0]   mean_value;
    bit [FloorW-1:0]           std_deviation;
    bit signed [SampleW-1:0]   low_percentile;
    bit signed [SampleW-1:0]   high_percentile;
    bit                        overflowed;
  } window_stats_t;

  class window_stats_book;
    longint sorted_vals[Capacity];
    int unsigned kept;
    longint total;
    bit dropped;
    int unsigned min_needed;
    longint unsigned sd_floor;
    window_stats_t pending_stats[$];
    int unsigned mismatches;
    int unsigned windows_checked;
    int unsigned valid_windows;
    int unsigned overflow_windows;

    function new();
      kept = 0;
      total = 0;
      dropped = 0;
      min_needed = MinCountRst;
      sd_floor = FloorRst;
      mismatches = 0;
      windows_checked = 0;
      valid_windows = 0;
      overflow_windows = 0;
    endfunction

    function void set_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == REG_MIN_COUNT) begin
        min_needed = data[MinCountW-1:0];
      end else if (idx == REG_STDDEV_FLOOR) begin
        sd_floor = data[FloorW-1:0];
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) begin
          r = trial;
        end
      end
      return r;
    endfunction

    function void note_item(logic signed [SampleW-1:0] x, bit miss, bit lst);
      window_stats_t e;
      int unsigned need;
      int unsigned i;
      int unsigned ilo;
      int unsigned ihi;
      longint s;
      longint m;
      longint d;
      longint unsigned sq;
      longint unsigned acc;
      longint unsigned sd;
      if (!miss) begin
        if (kept < Capacity) begin
          i = kept;
          while (i > 0 && sorted_vals[i-1] > longint'(x)) begin
            sorted_vals[i] = sorted_vals[i-1];
            i--;
          end
          sorted_vals[i] = x;
          kept++;
          total += x;
        end else begin
          dropped = 1;
        end
      end
      if (!lst) return;
      e = '0;
      need = (min_needed < 2) ? 2 : min_needed;
      e.kept_count = CountW'(kept);
      e.overflowed = dropped;
      if (kept >= need) begin
        e.stats_valid = 1'b1;
        if (kept % 2 == 1) begin
          e.median_value = SampleW'(sorted_vals[kept/2]);
        end else begin
          s = sorted_vals[kept/2-1] + sorted_vals[kept/2];
          e.median_value = SampleW'(s >>> 1);
        end
        m = total / longint'(kept);
        e.mean_value = SampleW'(m);
        acc = 0;
        for (int k = 0; k < kept; k++) begin
          d = sorted_vals[k] - m;
          if (d < 0) d = -d;
          sq = longint'(d) * longint'(d);
          acc = (acc > 64'hffff_ffff_ffff_ffff - sq) ? 64'hffff_ffff_ffff_ffff : acc + sq;
        end
        sd = int_sqrt(acc / longint'(kept - 1));
        if (sd > (64'd1 << (SampleW-1)) - 1) sd = (64'd1 << (SampleW-1)) - 1;
        if (sd < sd_floor) sd = sd_floor;
        e.std_deviation = FloorW'(sd);
        ilo = kept / PctDivisor;
        ihi = (PctHighMul * kept) / PctDivisor;
        if (ihi > kept - 1) ihi = kept - 1;
        e.low_percentile = SampleW'(sorted_vals[ilo]);
        e.high_percentile = SampleW'(sorted_vals[ihi]);
      end
      pending_stats = {pending_stats, e};
      kept = 0;
      total = 0;
      dropped = 0;
    endfunction

    function void check_beat(window_stats_t got);
      window_stats_t e;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, kept_count %0d", got.kept_count);
        return;
      end
      e = pending_stats.pop_front();
      windows_checked++;
      if (e.stats_valid) valid_windows++;
      if (e.overflowed) overflow_windows++;
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch on window %0d", windows_checked);
          $display("  expected v=%0d n=%0d med=%0d mean=%0d sd=%0d lo=%0d hi=%0d ovf=%0d",
                   e.stats_valid, e.kept_count, e.median_value, e.mean_value,
                   e.std_deviation, e.low_percentile, e.high_percentile, e.overflowed);
          $display("  actual   v=%0d n=%0d med=%0d mean=%0d sd=%0d lo=%0d hi=%0d ovf=%0d",
                   got.stats_valid, got.kept_count, got.median_value, got.mean_value,
                   got.std_deviation, got.low_percentile, got.high_percentile,
                   got.overflowed);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic missing_i;
  logic last_i;
  logic out_valid_o;
  logic out_ready_i;
  logic stats_valid_o;
  logic [CountW-1:0] kept_count_o;
  logic signed [SampleW-1:0] median_value_o;
  logic signed [SampleW-1:0] mean_value_o;
  logic [FloorW-1:0] std_deviation_o;
  logic signed [SampleW-1:0] low_percentile_o;
  logic signed [SampleW-1:0] high_percentile_o;
  logic overflowed_o;

  window_stats_book book;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned stall_left;
  int unsigned flow_left;

  window_order_statistics_core DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_i, .missing_i, .last_i,
    .out_valid_o, .out_ready_i, .stats_valid_o, .kept_count_o, .median_value_o,
    .mean_value_o, .std_deviation_o, .low_percentile_o, .high_percentile_o,
    .overflowed_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #5000000;
    $display("window_order_statistics_core test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    window_stats_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.stats_valid = stats_valid_o;
      got.kept_count = kept_count_o;
      got.median_value = median_value_o;
      got.mean_value = mean_value_o;
      got.std_deviation = std_deviation_o;
      got.low_percentile = low_percentile_o;
      got.high_percentile = high_percentile_o;
      got.overflowed = overflowed_o;
      book.check_beat(got);
    end
    if (flow_left > 0) begin
      flow_left--;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(3) == 0) begin
      flow_left = $urandom_range(60, 10);
      out_ready_i <= 1'b1;
    end else begin
      stall_left = $urandom_range(4);
      out_ready_i <= 1'($urandom_range(1));
    end
  end

  task automatic write_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    book.set_register(idx, data);
    @(posedge clk_i);
  endtask

  task automatic send_item(logic signed [SampleW-1:0] x, bit miss, bit lst);
    if (burst_left == 0) begin
      if ($urandom_range(2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
      burst_left = $urandom_range(20, 1);
    end
    in_valid_i <= 1'b1;
    sample_i <= x;
    missing_i <= miss;
    last_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_item(x, miss, lst);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample(int unsigned style,
                                                           logic signed [SampleW-1:0] base);
    case (style)
      0: return SampleW'($urandom);
      1: return base + SampleW'($urandom_range(15)) - SampleW'(8);
      default: return $urandom_range(1) ? {1'b0, {(SampleW-1){1'b1}}} : {1'b1, {(SampleW-1){1'b0}}};
    endcase
  endfunction

  task automatic random_window();
    int unsigned len;
    int unsigned style;
    int unsigned pick;
    logic signed [SampleW-1:0] base;
    pick = $urandom_range(9);
    if (pick < 8) len = $urandom_range(20, 1);
    else if (pick == 8) len = $urandom_range(Capacity, 40);
    else len = $urandom_range(Capacity + 10, Capacity + 1);
    style = ($urandom_range(9) == 0) ? 2 : $urandom_range(1);
    base = SampleW'($urandom);
    for (int k = 0; k < len; k++) begin
      send_item(pick_sample(style, base), $urandom_range(7) == 0, k == len - 1);
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] settings[7][2];
    book = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    missing_i = 1'b0;
    last_i = 1'b0;
    out_ready_i = 1'b0;
    burst_left = 0;
    items_sent = 0;
    stall_left = 0;
    flow_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);

    send_item(24'sh7fffff, 0, 0);
    send_item(-24'sh800000, 0, 0);
    send_item(24'sh000000, 0, 1);
    send_item(24'sh123456, 1, 1);
    send_item(24'sh000005, 0, 0);
    send_item(24'sh000007, 1, 1);
    send_item(-24'sh5, 0, 0);
    send_item(24'sh9, 0, 0);
    send_item(-24'sh3, 0, 0);
    send_item(24'sh0, 0, 0);
    send_item(24'sh44, 1, 1);
    for (int k = 0; k < 4; k++) send_item(24'sh010000, 0, k == 3);
    send_item(24'sh7fffff, 0, 0);
    send_item(24'sh7fffff, 0, 0);
    send_item(-24'sh800000, 0, 0);
    send_item(-24'sh800000, 0, 1);
    drain();

    settings = '{'{23'd3, 23'd3277}, '{23'd2, 23'd0}, '{23'd64, 23'h7fffff},
                 '{23'd0, 23'd1}, '{23'd1, 23'd0}, '{23'd127, 23'd0}, '{23'd0, 23'd0}};
    settings[4][1] = CfgDataW'($urandom);
    settings[5][1] = CfgDataW'($urandom_range(2000));
    settings[6][0] = CfgDataW'($urandom_range(16, 2));
    settings[6][1] = CfgDataW'($urandom);
    write_register(UnusedIndexA, CfgDataW'($urandom));
    for (int p = 0; p < 7; p++) begin
      write_register(REG_MIN_COUNT, {16'($urandom), settings[p][0][MinCountW-1:0]});
      write_register(REG_STDDEV_FLOOR, settings[p][1]);
      if (p == 3) write_register(UnusedIndexB, CfgDataW'($urandom));
      while (items_sent < 20 + (p + 1) * 105) random_window();
      drain();
    end

    $display("Ran %0d sample beats over %0d windows: %0d with statistics, %0d overflowed.",
             items_sent, book.windows_checked, book.valid_windows, book.overflow_windows);
    $display("Mismatches: %0d", book.mismatches);
    if (book.mismatches == 0 && book.pending_stats.size() == 0) begin
      $display("window_order_statistics_core test passed");
    end else begin
      $display("window_order_statistics_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/wos_pkg.sv
hdl/wos_divider.sv
hdl/wos_sqrt.sv
hdl/wos_datapath.sv
hdl/wos_ctrl.sv
hdl/window_order_statistics_core.sv
verif/window_order_statistics_core_test.sv
